/* design/pru_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the pixel replicate upscaler.
// Used by pru_ctrl, pru_lbuf, pru_out and pixel_replicate_upscaler.

package pru_pkg;

    localparam int DEF_MAX_WIDTH = 4096;
    localparam int DEF_MAX_SCALE = 100;

    localparam int CHAN_W        = 8;
    localparam int PIX_W         = 3 * CHAN_W;
    localparam int SCALE_FIELD_W = 7;
    localparam int WIDTH_FIELD_W = 13;
    localparam int HEIGHT_W      = 16;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int PAD_W         = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE  = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic is_padding;
        logic row_end;
        logic image_end;
    } res_flags_t;

endpackage

/* design/pru_lbuf.sv */
`timescale 1ns / 1ps
// Line buffer: one row of pixels, one write and one registered read per cycle.
// Depends on pru_pkg for the pixel width.

module pru_lbuf #(
    parameter int MAX_WIDTH = pru_pkg::DEF_MAX_WIDTH,
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  logic [pru_pkg::PIX_W-1:0] wdata,
    input  logic                     re,
    input  logic [AW-1:0]            raddr,
    output logic [pru_pkg::PIX_W-1:0] rdata
);

    logic [pru_pkg::PIX_W-1:0] mem [MAX_WIDTH];
    logic [pru_pkg::PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/pru_ctrl.sv */
`timescale 1ns / 1ps
// Upscaler control: configuration registers, row counters and line buffer access.
// Depends on pru_pkg for field widths, register indexes and result flags.

module pru_ctrl #(
    parameter int MAX_WIDTH = pru_pkg::DEF_MAX_WIDTH,
    parameter int MAX_SCALE = pru_pkg::DEF_MAX_SCALE,
    localparam int AW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int CNT_W   = $clog2(MAX_WIDTH + 1),
    localparam int SCALE_W = $clog2(MAX_SCALE + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [pru_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pru_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          op,
    input  logic [pru_pkg::CHAN_W-1:0]    blue,
    input  logic [pru_pkg::CHAN_W-1:0]    green,
    input  logic [pru_pkg::CHAN_W-1:0]    red,
    input  logic                          adv,
    output logic                          mem_we,
    output logic [AW-1:0]                 mem_waddr,
    output logic [pru_pkg::PIX_W-1:0]     mem_wdata,
    output logic                          mem_re,
    output logic [AW-1:0]                 mem_raddr,
    output logic                          res_valid,
    output pru_pkg::res_flags_t           res_flags
);

    logic [SCALE_W-1:0]           scale_reg;
    logic [CNT_W-1:0]             width_reg;
    logic [pru_pkg::HEIGHT_W-1:0] height_reg;

    logic [CNT_W-1:0]             loaded_reg, loaded_next;
    logic [SCALE_W-1:0]           replay_reg, replay_next;
    logic [CNT_W-1:0]             col_reg, col_next;
    logic [SCALE_W-1:0]           copy_reg, copy_next;
    logic [pru_pkg::PAD_W-1:0]    pad_reg, pad_next;
    logic [pru_pkg::HEIGHT_W-1:0] rows_reg, rows_next;
    logic                         res_valid_reg, res_valid_next;
    pru_pkg::res_flags_t          res_flags_reg, res_flags_next;

    logic [31:0]                  scale_wr, width_wr;
    logic                         accept, active, push_ok, req_ok, pix_branch, rend, iend;
    logic [pru_pkg::PAD_W-1:0]    pads;
    logic [SCALE_W-1:0]           copy_inc, replay_inc;
    logic [CNT_W-1:0]             col_inc;
    logic [pru_pkg::PAD_W-1:0]    pad_inc;
    logic [pru_pkg::HEIGHT_W-1:0] rows_inc;

    // Saturate scale and width writes to the configured maxima
    assign scale_wr = 32'(cfg_data[pru_pkg::SCALE_FIELD_W-1:0]);
    assign width_wr = 32'(cfg_data[pru_pkg::WIDTH_FIELD_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= SCALE_W'(1);
            width_reg  <= CNT_W'(1);
            height_reg <= pru_pkg::HEIGHT_W'(1);
        end
        else if (cfg_wr_en)
        begin
            case (pru_pkg::cfg_reg_t'(cfg_index))
                pru_pkg::REG_SCALE:
                begin
                    scale_reg <= (scale_wr > 32'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE)
                                                            : SCALE_W'(scale_wr);
                end
                pru_pkg::REG_WIDTH:
                begin
                    width_reg <= (width_wr > 32'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH)
                                                            : CNT_W'(width_wr);
                end
                pru_pkg::REG_HEIGHT:
                begin
                    height_reg <= cfg_data[pru_pkg::HEIGHT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // The result slot moves on when the output side can take it; hold input otherwise
    assign in_stall = res_valid_reg && !adv;
    assign accept   = in_valid && !in_stall;

    assign active     = (scale_reg != '0) && (width_reg != '0) && (height_reg != '0);
    assign push_ok    = active && !op && (loaded_reg < width_reg);
    assign req_ok     = active && op && (loaded_reg >= width_reg);
    assign pads       = pru_pkg::PAD_W'(pru_pkg::PAD_W'(width_reg) * pru_pkg::PAD_W'(scale_reg));
    assign pix_branch = col_reg < width_reg;

    assign copy_inc   = copy_reg + SCALE_W'(1);
    assign replay_inc = replay_reg + SCALE_W'(1);
    assign col_inc    = col_reg + CNT_W'(1);
    assign pad_inc    = pad_reg + pru_pkg::PAD_W'(1);
    assign rows_inc   = rows_reg + pru_pkg::HEIGHT_W'(1);

    always_comb
    begin
        loaded_next    = loaded_reg;
        replay_next    = replay_reg;
        col_next       = col_reg;
        copy_next      = copy_reg;
        pad_next       = pad_reg;
        rows_next      = rows_reg;
        rend           = 1'b0;
        iend           = 1'b0;
        res_valid_next = adv ? 1'b0 : res_valid_reg;
        res_flags_next = res_flags_reg;

        if (accept)
        begin
            res_valid_next = req_ok;
            if (push_ok)
            begin
                loaded_next = loaded_reg + CNT_W'(1);
            end
            if (req_ok)
            begin
                if (pix_branch)
                begin
                    copy_next = copy_inc;
                    if (copy_inc >= scale_reg)
                    begin
                        copy_next = '0;
                        col_next  = col_inc;
                        rend      = (col_inc >= width_reg) && (pads == '0);
                    end
                end
                else
                begin
                    pad_next = pad_inc;
                    rend     = pad_inc >= pads;
                end

                if (rend)
                begin
                    col_next    = '0;
                    copy_next   = '0;
                    pad_next    = '0;
                    replay_next = replay_inc;
                    if (replay_inc >= scale_reg)
                    begin
                        replay_next = '0;
                        loaded_next = '0;
                        rows_next   = rows_inc;
                        if (rows_inc >= height_reg)
                        begin
                            rows_next = '0;
                            iend      = 1'b1;
                        end
                    end
                end

                res_flags_next.is_padding = !pix_branch;
                res_flags_next.row_end    = rend;
                res_flags_next.image_end  = iend;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg    <= '0;
            replay_reg    <= '0;
            col_reg       <= '0;
            copy_reg      <= '0;
            pad_reg       <= '0;
            rows_reg      <= '0;
            res_valid_reg <= 1'b0;
            res_flags_reg <= '0;
        end
        else
        begin
            loaded_reg    <= loaded_next;
            replay_reg    <= replay_next;
            col_reg       <= col_next;
            copy_reg      <= copy_next;
            pad_reg       <= pad_next;
            rows_reg      <= rows_next;
            res_valid_reg <= res_valid_next;
            res_flags_reg <= res_flags_next;
        end
    end

    // Writes only happen before the row is complete and reads only after,
    // so the same entry is never written and read in one cycle.
    assign mem_we    = accept && push_ok;
    assign mem_waddr = AW'(loaded_reg);
    assign mem_wdata = {red, green, blue};
    assign mem_re    = accept && req_ok && pix_branch;
    assign mem_raddr = AW'(col_reg);

    assign res_valid = res_valid_reg;
    assign res_flags = res_flags_reg;

    a_loaded_bound: assert property (@(posedge clk) disable iff (!rst_n)
        loaded_reg <= CNT_W'(MAX_WIDTH))
        else $error("loaded count beyond line buffer depth");

    a_pad_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pad_reg != {pru_pkg::PAD_W{1'b1}})
        else $error("padding index reached an unused value");

    a_copy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (copy_reg < SCALE_W'(MAX_SCALE)) && (replay_reg < SCALE_W'(MAX_SCALE)))
        else $error("copy or replay index not wrapped");

    a_slot_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !adv |=> res_valid_reg && $stable(res_flags_reg))
        else $error("pending result overwritten");

endmodule

/* design/pru_out.sv */
`timescale 1ns / 1ps
// Output register: joins result flags with line buffer read data and holds them.
// Depends on pru_pkg for the result flag struct and widths.

module pru_out (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       res_valid,
    input  pru_pkg::res_flags_t        res_flags,
    input  logic [pru_pkg::PIX_W-1:0]  rd_data,
    output logic                       adv,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       is_padding,
    output logic [pru_pkg::CHAN_W-1:0] out_blue,
    output logic [pru_pkg::CHAN_W-1:0] out_green,
    output logic [pru_pkg::CHAN_W-1:0] out_red,
    output logic                       row_end,
    output logic                       image_end
);

    logic                      valid_reg, valid_next;
    pru_pkg::res_flags_t       flags_reg;
    logic [pru_pkg::PIX_W-1:0] pix_reg;
    logic                      load;

    assign adv        = !valid_reg || !out_stall;
    assign load       = res_valid && adv;
    assign valid_next = load ? 1'b1 : (out_stall ? valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            flags_reg <= res_flags;
            // Padding bytes carry zero color
            pix_reg   <= res_flags.is_padding ? '0 : rd_data;
        end
    end

    assign out_valid  = valid_reg;
    assign is_padding = flags_reg.is_padding;
    assign row_end    = flags_reg.row_end;
    assign image_end  = flags_reg.image_end;
    assign out_blue   = pix_reg[pru_pkg::CHAN_W-1:0];
    assign out_green  = pix_reg[2*pru_pkg::CHAN_W-1:pru_pkg::CHAN_W];
    assign out_red    = pix_reg[3*pru_pkg::CHAN_W-1:2*pru_pkg::CHAN_W];

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && flags_reg.is_padding |-> pix_reg == '0)
        else $error("padding element with nonzero color");

    a_image_row: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && flags_reg.image_end |-> flags_reg.row_end)
        else $error("image end without row end");

endmodule

/* design/pixel_replicate_upscaler.sv */
`timescale 1ns / 1ps
// Top level of the nearest-neighbor integer upscaler.
// Depends on pru_pkg, pru_ctrl, pru_lbuf and pru_out.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    op, blue, green, red
//   out      output     out_valid / out_stall  is_padding, out_blue/green/red, row_end, image_end
//   cfg      input      cfg_wr_en              cfg_index, cfg_data
//
// One item is taken per clock while in_stall is low. A request's transfer does the
// registered line buffer read and fills the result slot; the output register then loads
// the result when it is free or not stalled. Reset clears all counters and loads scale,
// width and height with one; the line buffer is not cleared. An output stall backs up
// into in_stall once both the result slot and the output register are full.

module pixel_replicate_upscaler #(
    parameter int MAX_WIDTH = pru_pkg::DEF_MAX_WIDTH,
    parameter int MAX_SCALE = pru_pkg::DEF_MAX_SCALE
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [pru_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pru_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          op,
    input  logic [pru_pkg::CHAN_W-1:0]    blue,
    input  logic [pru_pkg::CHAN_W-1:0]    green,
    input  logic [pru_pkg::CHAN_W-1:0]    red,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          is_padding,
    output logic [pru_pkg::CHAN_W-1:0]    out_blue,
    output logic [pru_pkg::CHAN_W-1:0]    out_green,
    output logic [pru_pkg::CHAN_W-1:0]    out_red,
    output logic                          row_end,
    output logic                          image_end
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic                      adv;
    logic                      mem_we, mem_re;
    logic [AW-1:0]             mem_waddr, mem_raddr;
    logic [pru_pkg::PIX_W-1:0] mem_wdata, mem_rdata;
    logic                      res_valid;
    pru_pkg::res_flags_t       res_flags;

    pru_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_SCALE (MAX_SCALE)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .blue      (blue),
        .green     (green),
        .red       (red),
        .adv       (adv),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .res_valid (res_valid),
        .res_flags (res_flags)
    );

    pru_lbuf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_lbuf (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pru_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .res_flags  (res_flags),
        .rd_data    (mem_rdata),
        .adv        (adv),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .is_padding (is_padding),
        .out_blue   (out_blue),
        .out_green  (out_green),
        .out_red    (out_red),
        .row_end    (row_end),
        .image_end  (image_end)
    );

endmodule

/* tb/sv/tb_pixel_replicate_upscaler.sv */
`timescale 1ns / 1ps
// Self-checking testbench for pixel_replicate_upscaler: a directed table, then random
// pixel streams checked against a cycle-free predictor of the upscaler.
// Depends on pru_pkg and the pixel_replicate_upscaler RTL.

module tb_pixel_replicate_upscaler;

    import pru_pkg::*;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_PULL = 1'b1;

    localparam int SETTLE_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int PHASE_ITEMS     = 73;
    localparam int PHASES_PER_MODE = 5;

    typedef struct packed {
        logic             is_padding;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic             row_end;
        logic             image_end;
    } px_res_t;

    // ROW_NONE: item that must give no result, ROW_TYPED: result typed in the row,
    // ROW_PREDICT: result taken from the predictor, ROW_WRITE: register write
    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_NONE,
        ROW_TYPED,
        ROW_PREDICT
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        cfg_reg_t          reg_sel;
        logic [CFG_W-1:0]  wdata;
        logic              op;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        px_res_t           want;
    } dir_row_t;

    localparam px_res_t NO_RES = '0;
    localparam int DIR_ROWS = 28;

    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // reset values: scale 1, width 1, height 1
        '{ROW_NONE,    REG_SCALE,  16'h0000, OP_PULL, 8'h00, 8'h00, 8'h00, NO_RES},
        '{ROW_PREDICT, REG_SCALE,  16'h0000, OP_PUSH, 8'hFF, 8'hFF, 8'hFF, NO_RES},
        '{ROW_NONE,    REG_SCALE,  16'h0000, OP_PUSH, 8'h12, 8'h34, 8'h56, NO_RES},
        '{ROW_TYPED,   REG_SCALE,  16'h0000, OP_PULL, 8'h00, 8'h00, 8'h00,
          '{1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0}},
        // one pad byte closes the only row and the image
        '{ROW_TYPED,   REG_SCALE,  16'h0000, OP_PULL, 8'h00, 8'h00, 8'h00,
          '{1'b1, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1}},
        '{ROW_NONE,    REG_SCALE,  16'h0000, OP_PULL, 8'hFF, 8'hFF, 8'hFF, NO_RES},
        // empty image: any zero register blocks pushes and pulls
        '{ROW_WRITE,   REG_SCALE,  16'h0000, OP_PUSH, 8'h00, 8'h00, 8'h00, NO_RES},
        '{ROW_NONE,    REG_SCALE,  16'h0000, OP_PUSH, 8'h5A, 8'hA5, 8'h3C, NO_RES},
        '{ROW_NONE,    REG_SCALE,  16'h0000, OP_PULL, 8'h00, 8'h00, 8'h00, NO_RES},
        '{ROW_WRITE,   REG_SCALE,  16'h0002, OP_PUSH, 8'h00, 8'h00, 8'h00, NO_RES},
        '{ROW_WRITE,   REG_WIDTH,  16'h0000, OP_PUSH, 8'h00, 8'h00, 8'h00, NO_RES},
        '{ROW_NONE,    REG_SCALE,  16'h0000, OP_PUSH, 8'hC3, 8'h3C, 8'h96, NO_RES},
        '{ROW_WRITE,   REG_WIDTH,  16'h0003, OP_PUSH, 8'h00, 8'h00, 8'h00, NO_RES},
        '{ROW_WRITE,   REG_HEIGHT, 16'h0000, OP_PUSH, 8'h00, 8'h00, 8'h00, NO_RES},
        '{ROW_NONE,    REG_SCALE,  16'h0000, OP_PULL, 8'h00, 8'h00, 8'h00, NO_RES},
        '{ROW_WRITE,   REG_HEIGHT, 16'hFFFF, OP_PUSH, 8'h00, 8'h00, 8'h00, NO_RES},
        // three pixels at scale two: two pad bytes per row
        '{ROW_PREDICT, REG_SCALE,  16'h0000, OP_PUSH, 8'h00, 8'h00, 8'h00, NO_RES},
        '{ROW_PREDICT, REG_SCALE,  16'h0000, OP_PUSH, 8'h80, 8'h01, 8'h7F, NO_RES},
        '{ROW_PREDICT, REG_SCALE,  16'h0000, OP_PUSH, 8'hFF, 8'hFE, 8'h01, NO_RES},
        '{ROW_PREDICT, REG_SCALE,  16'h0000, OP_PULL, 8'hFF, 8'hFF, 8'hFF, NO_RES},
        '{ROW_PREDICT, REG_SCALE,  16'h0000, OP_PULL, 8'h00, 8'h00, 8'h00, NO_RES},
        '{ROW_PREDICT, REG_SCALE,  16'h0000, OP_PULL, 8'hAA, 8'h55, 8'hAA, NO_RES},
        '{ROW_PREDICT, REG_SCALE,  16'h0000, OP_PULL, 8'h00, 8'h00, 8'h00, NO_RES},
        '{ROW_PREDICT, REG_SCALE,  16'h0000, OP_PULL, 8'h00, 8'h00, 8'h00, NO_RES},
        '{ROW_PREDICT, REG_SCALE,  16'h0000, OP_PULL, 8'h00, 8'h00, 8'h00, NO_RES},
        '{ROW_PREDICT, REG_SCALE,  16'h0000, OP_PULL, 8'h00, 8'h00, 8'h00, NO_RES},
        '{ROW_PREDICT, REG_SCALE,  16'h0000, OP_PULL, 8'h00, 8'h00, 8'h00, NO_RES},
        '{ROW_PREDICT, REG_SCALE,  16'h0000, OP_PULL, 8'h00, 8'h00, 8'h00, NO_RES}
    };

    logic                 clk;
    logic                 rst_n      = 1'b0;
    logic                 cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [CFG_W-1:0]     cfg_data   = '0;
    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    logic                 op         = OP_PUSH;
    logic [CHAN_W-1:0]    blue       = '0;
    logic [CHAN_W-1:0]    green      = '0;
    logic [CHAN_W-1:0]    red        = '0;
    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    logic                 is_padding;
    logic [CHAN_W-1:0]    out_blue;
    logic [CHAN_W-1:0]    out_green;
    logic [CHAN_W-1:0]    out_red;
    logic                 row_end;
    logic                 image_end;

    // predictor state
    logic [PIX_W-1:0] line_px [DEF_MAX_WIDTH];
    int unsigned loaded_px;
    int unsigned replay_pos;
    int unsigned col_pos;
    int unsigned copy_pos;
    int unsigned pad_pos;
    int unsigned rows_out;
    int unsigned cur_scale  = 1;
    int unsigned cur_width  = 1;
    int unsigned cur_height = 1;

    px_res_t pending_px [$];
    px_res_t got_px;
    px_res_t want_px;
    int      err_count     = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;

    pixel_replicate_upscaler i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .blue       (blue),
        .green      (green),
        .red        (red),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .is_padding (is_padding),
        .out_blue   (out_blue),
        .out_green  (out_green),
        .out_red    (out_red),
        .row_end    (row_end),
        .image_end  (image_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Advance the upscaler by one accepted item; returns 1 when it yields an element.
    function automatic bit upscale_step(input logic o, input logic [7:0] b, g, r,
                                        output px_res_t res);
        int unsigned pads;
        bit          closes_row;
        res        = '0;
        closes_row = 1'b0;
        if (cur_scale == 0 || cur_width == 0 || cur_height == 0)
            return 1'b0;
        if (o == OP_PUSH)
        begin
            if (loaded_px < cur_width)
            begin
                line_px[loaded_px] = {r, g, b};
                loaded_px++;
            end
            return 1'b0;
        end
        if (loaded_px < cur_width)
            return 1'b0;
        pads = (cur_width * cur_scale) & 3;
        if (col_pos < cur_width)
        begin
            {res.red, res.green, res.blue} = line_px[col_pos];
            copy_pos++;
            if (copy_pos >= cur_scale)
            begin
                copy_pos = 0;
                col_pos++;
                if (col_pos >= cur_width && pads == 0)
                    closes_row = 1'b1;
            end
        end
        else
        begin
            res.is_padding = 1'b1;
            pad_pos++;
            if (pad_pos >= pads)
                closes_row = 1'b1;
        end
        if (closes_row)
        begin
            res.row_end = 1'b1;
            col_pos     = 0;
            copy_pos    = 0;
            pad_pos     = 0;
            replay_pos++;
            if (replay_pos >= cur_scale)
            begin
                replay_pos = 0;
                loaded_px  = 0;
                rows_out++;
                if (rows_out >= cur_height)
                begin
                    rows_out      = 0;
                    res.image_end = 1'b1;
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic void report_field(input string name, input int want, input int got);
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        err_count++;
    endfunction

    // Output side: check each transfer, then pick the stall for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got_px = '{is_padding, out_blue, out_green, out_red, row_end, image_end};
                if (pending_px.size() == 0)
                begin
                    $display("%0t ns: output with nothing expected, expected none, got %h",
                             $time, got_px);
                    err_count++;
                end
                else
                begin
                    want_px = pending_px.pop_front();
                    if (got_px.is_padding !== want_px.is_padding)
                        report_field("is_padding", want_px.is_padding, got_px.is_padding);
                    if (got_px.blue !== want_px.blue)
                        report_field("out_blue", want_px.blue, got_px.blue);
                    if (got_px.green !== want_px.green)
                        report_field("out_green", want_px.green, got_px.green);
                    if (got_px.red !== want_px.red)
                        report_field("out_red", want_px.red, got_px.red);
                    if (got_px.row_end !== want_px.row_end)
                        report_field("row_end", want_px.row_end, got_px.row_end);
                    if (got_px.image_end !== want_px.image_end)
                        report_field("image_end", want_px.image_end, got_px.image_end);
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    // Entered and left just after a rising edge.
    task automatic send_item(input logic o, input logic [7:0] b, g, r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= o;
        blue     <= b;
        green    <= g;
        red      <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Hold the input until every expected element is out and the pipe is empty.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_px.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t sel, input logic [CFG_W-1:0] d);
        cfg_wr_en <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= d;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        case (sel)
            REG_SCALE:  cur_scale  = (d[6:0] > DEF_MAX_SCALE) ? DEF_MAX_SCALE : d[6:0];
            REG_WIDTH:  cur_width  = (d[12:0] > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : d[12:0];
            REG_HEIGHT: cur_height = 32'(d);
            default: ;
        endcase
    endtask

    task automatic random_config();
        int unsigned pick;
        int unsigned v;
        pick = $urandom_range(99);
        if (pick < 5)
            v = 0;
        else if (pick < 10)
            v = DEF_MAX_SCALE;
        else if (pick < 25)
            v = $urandom_range(8, 5);
        else
            v = $urandom_range(4, 1);
        // upper bits beyond the field are junk and must be dropped
        write_reg(REG_SCALE, {9'($urandom), 7'(v)});
        pick = $urandom_range(99);
        if (pick < 4)
            v = 0;
        else if (pick < 8)
            v = DEF_MAX_WIDTH;
        else
            v = $urandom_range(9, 1);
        write_reg(REG_WIDTH, {3'($urandom), 13'(v)});
        pick = $urandom_range(99);
        if (pick < 4)
            v = 0;
        else if (pick < 10)
            v = 16'hFFFF;
        else
            v = $urandom_range(3, 1);
        write_reg(REG_HEIGHT, 16'(v));
    endtask

    // Mostly well-formed: load the row, then drain it; now and then the wrong op.
    task automatic stream_phase(input int unsigned n_items);
        bit                push_now;
        bit                hit;
        px_res_t           res;
        logic [CHAN_W-1:0] b;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] r;
        for (int unsigned k = 0; k < n_items; k++)
        begin
            push_now = (loaded_px < cur_width);
            if ($urandom_range(99) < 8)
                push_now = !push_now;
            b = 8'($urandom);
            g = 8'($urandom);
            r = 8'($urandom);
            send_item(push_now ? OP_PUSH : OP_PULL, b, g, r);
            hit = upscale_step(push_now ? OP_PUSH : OP_PULL, b, g, r, res);
            if (hit)
                pending_px.push_back(res);
        end
    endtask

    initial
    begin
        dir_row_t row;
        bit       hit;
        px_res_t  res;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 22;
        recv_idle_pct = 66;
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = DIR_TABLE[i];
            if (row.kind == ROW_WRITE)
            begin
                settle();
                write_reg(row.reg_sel, row.wdata);
            end
            else
            begin
                send_item(row.op, row.blue, row.green, row.red);
                hit = upscale_step(row.op, row.blue, row.green, row.red, res);
                if (row.kind == ROW_TYPED)
                    pending_px.push_back(row.want);
                else if (row.kind == ROW_PREDICT && hit)
                    pending_px.push_back(res);
            end
        end

        // phases end wherever the stream is, so later settings land mid-row
        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 22 : (mode == 1) ? 66 : 0;
            recv_idle_pct = (mode == 0) ? 66 : (mode == 1) ? 22 : 0;
            for (int ph = 0; ph < PHASES_PER_MODE; ph++)
            begin
                settle();
                random_config();
                stream_phase(PHASE_ITEMS);
            end
        end

        // scale above range: first row end must come after one hundred copies
        settle();
        write_reg(REG_SCALE, 16'd127);
        write_reg(REG_WIDTH, 16'd1);
        write_reg(REG_HEIGHT, 16'd1);
        stream_phase(260);

        // width above range: pushes into the widest line keep requests silent
        settle();
        write_reg(REG_SCALE, 16'd1);
        write_reg(REG_WIDTH, 16'h1FFF);
        stream_phase(60);

        settle();
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
